/* src/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, widths and helpers for the reachable pair counter.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int COUNT_W     = NODE_W + 1;
  localparam int TOTAL_W     = 13;
  localparam int QPTR_W      = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [PADDR_W-3:0] REG_NODE_COUNT   = '0;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(64);
  localparam logic               KIND_COMPUTE     = 1'b1;

  typedef enum logic {
    OP_EDGE,
    OP_COMPUTE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_MERGE
  } back_state_t;

  // Saturate the programmed node count to the matrix size.
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] nc);
    logic [COUNT_W-1:0] res;
    if (nc > COUNT_W'(MAX_NODES)) res = COUNT_W'(MAX_NODES);
    else res = nc;
    return res;
  endfunction

endpackage

/* src/rpc_front.sv */
// ----------------------------------------------------------------------------
// rpc_front
// Accepts input requests, drops out-of-range edges, and queues the rest
// as commands for the back end.
// ----------------------------------------------------------------------------
module rpc_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic [rpc_pkg::NODE_W-1:0]         src_node,
  input  logic [rpc_pkg::NODE_W-1:0]         dst_node,
  input  logic [rpc_pkg::COUNT_W-1:0]        n_eff,
  output logic                               q_valid,
  output rpc_pkg::cmd_t                      q_cmd,
  input  logic                               q_pop
);

  rpc_pkg::cmd_t               slots [rpc_pkg::QUEUE_DEPTH];
  logic [rpc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [rpc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [rpc_pkg::QCNT_W-1:0]  count;
  logic                        keep;
  logic                        push;
  logic                        pop;
  rpc_pkg::cmd_t               cmd_in;

  assign in_ready = (count != rpc_pkg::QCNT_W'(rpc_pkg::QUEUE_DEPTH));

  always_comb begin
    cmd_in.op  = (kind == rpc_pkg::KIND_COMPUTE) ? rpc_pkg::OP_COMPUTE : rpc_pkg::OP_EDGE;
    cmd_in.src = src_node;
    cmd_in.dst = dst_node;
    // drop edges that name a node outside the active range
    keep = (cmd_in.op == rpc_pkg::OP_COMPUTE) ||
           ((rpc_pkg::COUNT_W'(src_node) < n_eff) && (rpc_pkg::COUNT_W'(dst_node) < n_eff));
  end

  assign push    = in_valid && in_ready && keep;
  assign pop     = q_pop && q_valid;
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* src/rpc_back.sv */
// ----------------------------------------------------------------------------
// rpc_back
// Holds the adjacency matrix, applies edge commands, and walks every
// source on a compute command to sum the reachable node counts.
// ----------------------------------------------------------------------------
module rpc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rpc_pkg::COUNT_W-1:0]   n_eff,
  input  logic                          q_valid,
  input  rpc_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpc_pkg::TOTAL_W-1:0]   reachable_pairs
);

  localparam int N = rpc_pkg::MAX_NODES;

  rpc_pkg::back_state_t        state, state_next;
  logic [N-1:0]                adj_mem [N];
  logic [N-1:0]                row_valid;
  logic [N-1:0]                reach, reach_next;
  logic [N-1:0]                done_set, done_set_next;
  logic [rpc_pkg::NODE_W-1:0]  src_idx, src_idx_next;
  logic [rpc_pkg::TOTAL_W-1:0] total, total_next;
  logic                        out_valid_next;
  logic [rpc_pkg::TOTAL_W-1:0] out_data_next;
  logic [N-1:0]                rd_row;
  logic                        rd_hit;
  logic [N-1:0]                pend;
  logic [N-1:0]                node_mask;
  logic [rpc_pkg::NODE_W-1:0]  pick_v;
  logic                        last_src;
  logic                        out_free;
  logic                        wr_en;
  logic                        rd_en;
  logic                        clear_rows;
  logic                        done_go;
  logic [N-1:0]                wr_bits;
  logic [N-1:0]                wr_mask;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      node_mask[i] = (rpc_pkg::COUNT_W'(i) < n_eff);
    end
  end

  // lowest reached node not yet expanded
  always_comb begin
    pick_v = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (pend[i]) pick_v = rpc_pkg::NODE_W'(i);
    end
  end

  assign pend     = reach & ~done_set;
  assign last_src = (rpc_pkg::COUNT_W'(src_idx) == (n_eff - 1'b1));
  assign out_free = !out_valid || out_ready;
  assign done_go  = (state == rpc_pkg::ST_PICK) && (pend == '0) && last_src && out_free;

  always_comb begin
    state_next     = state;
    reach_next     = reach;
    done_set_next  = done_set;
    src_idx_next   = src_idx;
    total_next     = total;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = reachable_pairs;
    q_pop          = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    clear_rows     = 1'b0;
    case (state)
      rpc_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == rpc_pkg::OP_EDGE) begin
            wr_en = 1'b1;
            q_pop = 1'b1;
          end else if (n_eff == '0) begin
            if (out_free) begin
              out_valid_next = 1'b1;
              out_data_next  = '0;
              clear_rows     = 1'b1;
              q_pop          = 1'b1;
            end
          end else begin
            src_idx_next  = '0;
            reach_next    = N'(1);
            done_set_next = '0;
            total_next    = '0;
            state_next    = rpc_pkg::ST_PICK;
          end
        end
      end
      rpc_pkg::ST_PICK: begin
        if (pend != '0) begin
          rd_en         = 1'b1;
          done_set_next = done_set | (N'(1) << pick_v);
          total_next    = total + 1'b1;
          state_next    = rpc_pkg::ST_MERGE;
        end else if (last_src) begin
          // hold the total until the output register frees up
          if (out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = total;
            clear_rows     = 1'b1;
            q_pop          = 1'b1;
            state_next     = rpc_pkg::ST_IDLE;
          end
        end else begin
          src_idx_next  = src_idx + 1'b1;
          reach_next    = N'(1) << (src_idx + 1'b1);
          done_set_next = '0;
        end
      end
      rpc_pkg::ST_MERGE: begin
        reach_next = reach | ((rd_hit ? rd_row : '0) & node_mask);
        state_next = rpc_pkg::ST_PICK;
      end
      default: begin
        state_next = rpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rpc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    reach           <= reach_next;
    done_set        <= done_set_next;
    src_idx         <= src_idx_next;
    total           <= total_next;
    reachable_pairs <= out_data_next;
  end

  // a stale row writes its whole word, a live row only the new bit
  assign wr_bits = N'(1) << q_cmd.dst;
  assign wr_mask = row_valid[q_cmd.src] ? wr_bits : '1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < N; i++) begin
        if (wr_mask[i]) adj_mem[q_cmd.src][i] <= wr_bits[i];
      end
    end
    if (rd_en) begin
      rd_row <= adj_mem[pick_v];
      rd_hit <= row_valid[pick_v];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (clear_rows) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[q_cmd.src] <= 1'b1;
    end
  end

  a_pick_to_merge: assert property (@(posedge clk) disable iff (rst)
    (state == rpc_pkg::ST_PICK && pend != '0) |=> (state == rpc_pkg::ST_MERGE))
    else $error("expanded node not merged in the next cycle");

  a_done_in_reach: assert property (@(posedge clk) disable iff (rst)
    (state == rpc_pkg::ST_PICK) |-> ((done_set & ~reach) == '0))
    else $error("expanded node outside reach set");

  a_total_floor: assert property (@(posedge clk) disable iff (rst)
    done_go |-> (total >= rpc_pkg::TOTAL_W'(n_eff)))
    else $error("total below one per source");

  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    done_go |=> (row_valid == '0 && out_valid))
    else $error("matrix not cleared or result lost at end of compute");

endmodule

/* src/reachable_pair_counter_core.sv */
// ----------------------------------------------------------------------------
// reachable_pair_counter_core
// Adjacency matrix loader and transitive reachability counter.
// ----------------------------------------------------------------------------
// Edge requests: one per cycle sustained while no compute is in progress; an
// edge waits in a 4-entry command queue until the back end writes it to the matrix.
// Compute request: the walker visits every source in turn and reads the matrix
// one row at a time, a PICK step then a MERGE step for each reached node.
// Reset: node_count returns to 64, row valid bits clear the matrix at once,
// queue and output register empty; no clearing pass.
module reachable_pair_counter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [rpc_pkg::NODE_W-1:0]    src_node,
  input  logic [rpc_pkg::NODE_W-1:0]    dst_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rpc_pkg::TOTAL_W-1:0]   reachable_pairs,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [rpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [rpc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [rpc_pkg::COUNT_W-1:0] node_count;
  logic [rpc_pkg::COUNT_W-1:0] n_eff;
  logic                        reg_hit;
  logic                        q_valid;
  logic                        q_pop;
  rpc_pkg::cmd_t               q_cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[rpc_pkg::PADDR_W-1:2] == rpc_pkg::REG_NODE_COUNT);
  assign prdata  = reg_hit ? rpc_pkg::PDATA_W'(node_count) : '0;
  assign n_eff   = rpc_pkg::eff_count(node_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= rpc_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count <= pwdata[rpc_pkg::COUNT_W-1:0];
    end
  end

  rpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .src_node (src_node),
    .dst_node (dst_node),
    .n_eff    (n_eff),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  rpc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .n_eff           (n_eff),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .reachable_pairs (reachable_pairs)
  );

endmodule
